[src/tdsfe_pkg.sv]
// Package of the three-digit segment frame encoder: widths, codes, reset values,
// payload and sideband types, and the digit-to-segment lookup.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package tdsfe_pkg;

    // Width of the signed value to be shown.
    localparam int VALUE_BITS = 16;

    // Width of a magnitude taken modulo 1000 (0 to 999).
    localparam int REM_BITS = 10;

    localparam int ADDR_BITS  = 6;
    localparam int PAT_BITS   = 7;
    localparam int BANK_BITS  = 35;
    localparam int DIGIT_BITS = 4;
    localparam int TENS_BITS  = 7;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = BANK_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEVICE_ADDRESS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MINUS_PATTERN  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIGITS_LOW     = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIGITS_HIGH    = CFG_INDEX_BITS'(3);

    // Register values after reset.
    localparam logic [ADDR_BITS-1:0] DEVICE_ADDRESS_RESET = ADDR_BITS'(0);
    localparam logic [PAT_BITS-1:0]  MINUS_PATTERN_RESET  = PAT_BITS'(64);
    localparam logic [BANK_BITS-1:0] DIGITS_LOW_RESET     = 35'd27547583295;
    localparam logic [BANK_BITS-1:0] DIGITS_HIGH_RESET    = 35'd30062804717;

    // Frame constants.
    localparam logic [7:0] HEADER_BASE  = 8'h80;
    localparam logic [7:0] COMMAND_CODE = 8'h12;

    // Error patterns, chosen by bit 0 of the device address.
    localparam logic [PAT_BITS-1:0] ERR_EVEN_LEFT   = 7'h7c;
    localparam logic [PAT_BITS-1:0] ERR_EVEN_MIDDLE = 7'h50;
    localparam logic [PAT_BITS-1:0] ERR_EVEN_RIGHT  = 7'h5c;
    localparam logic [PAT_BITS-1:0] ERR_ODD_LEFT    = 7'h5e;
    localparam logic [PAT_BITS-1:0] ERR_ODD_MIDDLE  = 7'h79;
    localparam logic [PAT_BITS-1:0] ERR_ODD_RIGHT   = 7'h5e;

    typedef struct packed {
        logic                         func;
        logic signed [VALUE_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          address_byte;
        logic [7:0]          command_byte;
        logic [PAT_BITS-1:0] digit_left;
        logic [PAT_BITS-1:0] digit_middle;
        logic [PAT_BITS-1:0] digit_right;
    } out_item_t;

    // Sideband that travels with each item down the pipeline.
    typedef struct packed {
        logic func;
        logic neg;
    } tag_t;

    // Live configuration seen by the frame builder.
    typedef struct packed {
        logic [ADDR_BITS-1:0] device_address;
        logic [PAT_BITS-1:0]  minus_pattern;
        logic [BANK_BITS-1:0] digits_low;
        logic [BANK_BITS-1:0] digits_high;
    } cfg_t;

    function automatic logic [PAT_BITS-1:0] seg_of(
        input logic [DIGIT_BITS-1:0] d,
        input logic [BANK_BITS-1:0]  low,
        input logic [BANK_BITS-1:0]  high
    );
        logic [PAT_BITS-1:0] pat;
        case (d)
            4'd0: pat = low[0  +: PAT_BITS];
            4'd1: pat = low[7  +: PAT_BITS];
            4'd2: pat = low[14 +: PAT_BITS];
            4'd3: pat = low[21 +: PAT_BITS];
            4'd4: pat = low[28 +: PAT_BITS];
            4'd5: pat = high[0  +: PAT_BITS];
            4'd6: pat = high[7  +: PAT_BITS];
            4'd7: pat = high[14 +: PAT_BITS];
            4'd8: pat = high[21 +: PAT_BITS];
            4'd9: pat = high[28 +: PAT_BITS];
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

[src/three_digit_segment_frame_encoder.sv]
// Top level of the three-digit segment frame encoder: configuration registers
// and the five-stage pipeline. Depends on tdsfe_pkg, tdsfe_mod1000, tdsfe_digits, tdsfe_frame.
//
//   Channel   Ports                                     Moves
//   --------  ----------------------------------------  ------------------------------
//   input     s_valid, s_ready, s_data                  func and signed value
//   result    m_valid, m_ready, m_data                  one LED-driver write frame
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data register writes, index 0 to 3
//
// One input transfer is taken per clock cycle when the pipeline is not blocked.
// On its way to the result, the magnitude, the 16 by 17 bit reciprocal product, the
// modulo-1000 remainder, the hundreds split and the frame register each take one stage.
// Each stage holds its item while the next is full and stalled, so the block keeps
// taking items until all five stages are occupied behind a stalled result.
// The synchronous active-low reset empties the pipeline and restores every
// configuration register to its documented value; the config channel is always ready.
`timescale 1ns / 1ps

module three_digit_segment_frame_encoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tdsfe_pkg::in_item_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output tdsfe_pkg::out_item_t                  m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tdsfe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tdsfe_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tdsfe_pkg::*;

    // Configuration registers. Writes to an index beyond the list are dropped.
    logic [ADDR_BITS-1:0] device_address_reg;
    logic [PAT_BITS-1:0]  minus_pattern_reg;
    logic [BANK_BITS-1:0] digits_low_reg;
    logic [BANK_BITS-1:0] digits_high_reg;
    cfg_t                 cfg;

    // Links between the pipeline sections.
    logic                  rem_valid, rem_ready;
    logic [REM_BITS-1:0]   rem;
    tag_t                  rem_tag;
    logic                  dig_valid, dig_ready;
    logic [DIGIT_BITS-1:0] dig_hundreds;
    logic [TENS_BITS-1:0]  dig_low;
    tag_t                  dig_tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            minus_pattern_reg  <= MINUS_PATTERN_RESET;
            digits_low_reg     <= DIGITS_LOW_RESET;
            digits_high_reg    <= DIGITS_HIGH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: begin
                    device_address_reg <= cfg_data[ADDR_BITS-1:0];
                end
                CFG_MINUS_PATTERN: begin
                    minus_pattern_reg <= cfg_data[PAT_BITS-1:0];
                end
                CFG_DIGITS_LOW: begin
                    digits_low_reg <= cfg_data[BANK_BITS-1:0];
                end
                CFG_DIGITS_HIGH: begin
                    digits_high_reg <= cfg_data[BANK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.device_address = device_address_reg;
        cfg.minus_pattern  = minus_pattern_reg;
        cfg.digits_low     = digits_low_reg;
        cfg.digits_high    = digits_high_reg;
    end

    // Magnitude and reduction modulo 1000: three stages.
    tdsfe_mod1000 u_mod1000 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (rem_valid),
        .out_ready (rem_ready),
        .out_rem   (rem),
        .out_tag   (rem_tag)
    );

    // Hundreds digit and the part below 100: one stage.
    tdsfe_digits u_digits (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (rem_valid),
        .in_ready     (rem_ready),
        .in_rem       (rem),
        .in_tag       (rem_tag),
        .out_valid    (dig_valid),
        .out_ready    (dig_ready),
        .out_hundreds (dig_hundreds),
        .out_low      (dig_low),
        .out_tag      (dig_tag)
    );

    // Tens, units, segment mapping and the result register: one stage.
    tdsfe_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (dig_valid),
        .in_ready    (dig_ready),
        .in_hundreds (dig_hundreds),
        .in_low      (dig_low),
        .in_tag      (dig_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[src/tdsfe_mod1000.sv]
// Three-stage pipeline that takes the magnitude of the signed value and reduces
// it modulo 1000 by reciprocal multiplication. Depends on tdsfe_pkg.
`timescale 1ns / 1ps

module tdsfe_mod1000 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tdsfe_pkg::in_item_t              in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tdsfe_pkg::REM_BITS-1:0]   out_rem,
    output tdsfe_pkg::tag_t                  out_tag
);
    import tdsfe_pkg::*;

    localparam int MAG_BITS  = VALUE_BITS;
    localparam int SHIFT     = MAG_BITS + REM_BITS;
    localparam int PROD_BITS = 2 * MAG_BITS + 1;
    localparam int WIDE_BITS = MAG_BITS + REM_BITS;
    localparam int DIVISOR   = 1000;
    // Rounded-up reciprocal of 1000, exact for every MAG_BITS-bit magnitude.
    localparam logic [MAG_BITS:0] RECIP =
        (MAG_BITS + 1)'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

    logic                 a_valid_reg, b_valid_reg, c_valid_reg;
    logic                 a_ready, b_ready, c_ready;
    logic [MAG_BITS-1:0]  a_mag_reg, b_mag_reg;
    tag_t                 a_tag_reg, b_tag_reg, c_tag_reg;
    logic [PROD_BITS-1:0] b_prod_reg;
    logic [REM_BITS-1:0]  c_rem_reg;

    logic [MAG_BITS-1:0]  raw;
    logic [MAG_BITS-1:0]  a_mag_next;
    tag_t                 a_tag_next;
    logic [PROD_BITS-1:0] b_prod_next;
    logic [MAG_BITS-1:0]  quot;
    logic [WIDE_BITS-1:0] rem_wide;
    logic [REM_BITS-1:0]  c_rem_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        raw            = in_data.value;
        a_tag_next.func = in_data.func;
        a_tag_next.neg  = raw[MAG_BITS-1];
        a_mag_next     = raw[MAG_BITS-1] ? (~raw + MAG_BITS'(1)) : raw;
        b_prod_next    = PROD_BITS'(a_mag_reg) * PROD_BITS'(RECIP);
        quot           = MAG_BITS'(b_prod_reg >> SHIFT);
        rem_wide       = WIDE_BITS'(b_mag_reg) - WIDE_BITS'(quot) * WIDE_BITS'(DIVISOR);
        c_rem_next     = rem_wide[REM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_mag_reg <= a_mag_next;
            a_tag_reg <= a_tag_next;
        end
        if (b_ready && a_valid_reg) begin
            b_prod_reg <= b_prod_next;
            b_mag_reg  <= a_mag_reg;
            b_tag_reg  <= a_tag_reg;
        end
        if (c_ready && b_valid_reg) begin
            c_rem_reg <= c_rem_next;
            c_tag_reg <= b_tag_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_rem   = c_rem_reg;
    assign out_tag   = c_tag_reg;

endmodule

[src/tdsfe_digits.sv]
// Pipeline stage that splits a value below 1000 into its hundreds digit and the
// remainder below 100. Depends on tdsfe_pkg.
`timescale 1ns / 1ps

module tdsfe_digits (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tdsfe_pkg::REM_BITS-1:0]     in_rem,
    input  tdsfe_pkg::tag_t                    in_tag,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tdsfe_pkg::DIGIT_BITS-1:0]   out_hundreds,
    output logic [tdsfe_pkg::TENS_BITS-1:0]    out_low,
    output tdsfe_pkg::tag_t                    out_tag
);
    import tdsfe_pkg::*;

    logic                  valid_reg;
    logic [DIGIT_BITS-1:0] hundreds_reg, hundreds_next;
    logic [TENS_BITS-1:0]  low_reg, low_next;
    tag_t                  tag_reg;
    logic [15:0]           scaled;
    logic [REM_BITS-1:0]   low_wide;

    // x * 41 / 4096 equals x / 100 for every x below 1000.
    always_comb begin
        scaled        = 16'(in_rem) * 16'd41;
        hundreds_next = scaled[15:12];
        low_wide      = in_rem - REM_BITS'(hundreds_next) * REM_BITS'(100);
        low_next      = low_wide[TENS_BITS-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hundreds_reg <= hundreds_next;
            low_reg      <= low_next;
            tag_reg      <= in_tag;
        end
    end

    assign out_valid    = valid_reg;
    assign out_hundreds = hundreds_reg;
    assign out_low      = low_reg;
    assign out_tag      = tag_reg;

endmodule

[src/tdsfe_frame.sv]
// Output stage: finishes the tens and units digits, maps digits to segment
// patterns with blanking and sign, and holds the frame register. Depends on tdsfe_pkg.
`timescale 1ns / 1ps

module tdsfe_frame (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tdsfe_pkg::cfg_t                    cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tdsfe_pkg::DIGIT_BITS-1:0]   in_hundreds,
    input  logic [tdsfe_pkg::TENS_BITS-1:0]    in_low,
    input  tdsfe_pkg::tag_t                    in_tag,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tdsfe_pkg::out_item_t               m_data
);
    import tdsfe_pkg::*;

    logic                  valid_reg;
    out_item_t             frame_reg, frame_next;
    logic [13:0]           scaled;
    logic [DIGIT_BITS-1:0] d2, d1, d0;
    logic [TENS_BITS-1:0]  units_wide;
    logic [PAT_BITS-1:0]   left, middle, right;

    always_comb begin
        // x * 103 / 1024 equals x / 10 for every x below 100.
        d2         = in_hundreds;
        scaled     = 14'(in_low) * 14'd103;
        d1         = scaled[13:10];
        units_wide = in_low - TENS_BITS'(d1) * TENS_BITS'(10);
        d0         = units_wide[DIGIT_BITS-1:0];

        if (in_tag.func) begin
            if (cfg.device_address[0]) begin
                left   = ERR_ODD_LEFT;
                middle = ERR_ODD_MIDDLE;
                right  = ERR_ODD_RIGHT;
            end else begin
                left   = ERR_EVEN_LEFT;
                middle = ERR_EVEN_MIDDLE;
                right  = ERR_EVEN_RIGHT;
            end
        end else begin
            left   = (d2 == '0) ? '0 : seg_of(d2, cfg.digits_low, cfg.digits_high);
            middle = (d2 == '0 && d1 == '0) ? '0
                                             : seg_of(d1, cfg.digits_low, cfg.digits_high);
            right  = seg_of(d0, cfg.digits_low, cfg.digits_high);
            // The sign sits left of the first shown nonzero digit, if there is room.
            if (in_tag.neg) begin
                if (d2 == '0 && d1 != '0) begin
                    left = cfg.minus_pattern;
                end else if (d2 == '0 && d1 == '0 && d0 != '0) begin
                    middle = cfg.minus_pattern;
                end
            end
        end

        frame_next.address_byte = HEADER_BASE | {1'b0, cfg.device_address, 1'b0};
        frame_next.command_byte = COMMAND_CODE;
        frame_next.digit_left   = left;
        frame_next.digit_middle = middle;
        frame_next.digit_right  = right;
    end

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            frame_reg <= frame_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = frame_reg;

endmodule

[dv/tdsfe_frame_checker.sv]
// Checker of the three-digit segment frame encoder: follows the configuration
// writes, predicts a frame for every input transfer and compares result transfers.
// Depends on tdsfe_pkg.
`timescale 1ns / 1ps

module tdsfe_frame_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  tdsfe_pkg::in_item_t                  s_data,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  tdsfe_pkg::out_item_t                 m_data,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [tdsfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tdsfe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   frames_pending
);
    import tdsfe_pkg::*;

    logic [ADDR_BITS-1:0] chip_addr;
    logic [PAT_BITS-1:0]  minus_shape;
    logic [BANK_BITS-1:0] low_bank;
    logic [BANK_BITS-1:0] high_bank;

    out_item_t frames_due[$];

    function automatic logic [PAT_BITS-1:0] digit_shape(input int unsigned d);
        logic [BANK_BITS-1:0] bank;
        bank = (d < 5) ? low_bank : high_bank;
        return PAT_BITS'(bank >> (PAT_BITS * (d % 5)));
    endfunction

    function automatic out_item_t predict_frame(input in_item_t item);
        out_item_t   f;
        int          mag;
        int unsigned units;
        int unsigned tens;
        int unsigned hundreds;
        logic        neg;
        f.address_byte = HEADER_BASE | (8'(chip_addr) << 1);
        f.command_byte = COMMAND_CODE;
        if (item.func) begin
            if (chip_addr[0]) begin
                f.digit_left   = ERR_ODD_LEFT;
                f.digit_middle = ERR_ODD_MIDDLE;
                f.digit_right  = ERR_ODD_RIGHT;
            end else begin
                f.digit_left   = ERR_EVEN_LEFT;
                f.digit_middle = ERR_EVEN_MIDDLE;
                f.digit_right  = ERR_EVEN_RIGHT;
            end
        end else begin
            mag = int'($signed(item.value));
            neg = (mag < 0);
            if (neg) begin
                mag = -mag;
            end
            units    = mag % 10;
            tens     = (mag / 10) % 10;
            hundreds = (mag / 100) % 10;
            f.digit_left   = (hundreds == 0) ? '0 : digit_shape(hundreds);
            f.digit_middle = (hundreds == 0 && tens == 0) ? '0 : digit_shape(tens);
            f.digit_right  = digit_shape(units);
            if (neg && hundreds == 0) begin
                if (tens != 0) begin
                    f.digit_left = minus_shape;
                end else if (units != 0) begin
                    f.digit_middle = minus_shape;
                end
            end
        end
        return f;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            chip_addr   = DEVICE_ADDRESS_RESET;
            minus_shape = MINUS_PATTERN_RESET;
            low_bank    = DIGITS_LOW_RESET;
            high_bank   = DIGITS_HIGH_RESET;
            frames_due.delete();
            fail_count  = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEVICE_ADDRESS: chip_addr   = cfg_data[ADDR_BITS-1:0];
                    CFG_MINUS_PATTERN:  minus_shape = cfg_data[PAT_BITS-1:0];
                    CFG_DIGITS_LOW:     low_bank    = cfg_data[BANK_BITS-1:0];
                    CFG_DIGITS_HIGH:    high_bank   = cfg_data[BANK_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    $error("frame with no prediction waiting: %p", m_data);
                    fail_count++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("address_byte", want.address_byte, m_data.address_byte);
                    check_field("command_byte", want.command_byte, m_data.command_byte);
                    check_field("digit_left", want.digit_left, m_data.digit_left);
                    check_field("digit_middle", want.digit_middle, m_data.digit_middle);
                    check_field("digit_right", want.digit_right, m_data.digit_right);
                end
            end
            if (s_valid && s_ready) begin
                frames_due.push_back(predict_frame(s_data));
            end
        end
        frames_pending = frames_due.size();
    end

endmodule

[dv/three_digit_segment_frame_encoder_tb.sv]
// Testbench top of the three-digit segment frame encoder: clock, reset, stimulus,
// back-pressure and the verdict. Depends on tdsfe_pkg, the block and tdsfe_frame_checker.
`timescale 1ns / 1ps

module three_digit_segment_frame_encoder_tb;

    import tdsfe_pkg::*;

    // A long hold-off of the receiver must outlast the five pipeline stages by a wide
    // margin so that the input channel is seen to stall.
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int ITEMS_PER_PHASE  = 250;
    localparam int PHASES           = 7;
    localparam int DRAIN_CYCLES     = 10;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_item_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    out_item_t                 m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int fail_count;
    int frames_pending;

    // Pace of idling on both sides: 0 means none, 1 light, 2 heavy.
    int pace = 1;
    // The stimulus asks for a long receiver hold-off by raising holds_asked; the
    // receiver process counts the ones it has carried out in holds_granted.
    int holds_asked   = 0;
    int holds_granted = 0;

    three_digit_segment_frame_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tdsfe_frame_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Generous ceiling: the slowest correct run, with every item meeting the longest
    // sender gap and the longest receiver stall, stays far below it.
    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Idle stretches are mostly short, now and then of medium length, and only seldom long.
    function automatic int pick_gap(input int level);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (level == 0) begin
            return 0;
        end
        if (roll < ((level == 1) ? 80 : 50)) begin
            return $urandom_range(1, 3);
        end
        if (roll < ((level == 1) ? 98 : 85)) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic in_item_t make_item(input logic show_error, input int number);
        in_item_t it;
        it.func  = show_error;
        it.value = number[VALUE_BITS-1:0];
        return it;
    endfunction

    // Values are weighted towards the places where the display logic changes its mind:
    // around zero, around multiples of a thousand, and at the ends of the range.
    function automatic int random_value();
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($signed(16'($urandom)));
            1: v = int'($urandom_range(0, 2200)) - 1100;
            2: v = (int'($urandom_range(0, 64)) - 32) * 1000 + int'($urandom_range(0, 30)) - 15;
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    v = 32767 - int'($urandom_range(0, 3));
                end else begin
                    v = -32768 + int'($urandom_range(0, 3));
                end
            end
        endcase
        return v;
    endfunction

    function automatic in_item_t random_item();
        return make_item($urandom_range(0, 7) == 0, random_value());
    endfunction

    // Called at a falling edge and returns at one. The valid stays high after the
    // transfer so that back-to-back items never lower and raise it in one step.
    task automatic offer_item(input in_item_t it, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data  <= make_item(1'($urandom_range(0, 1)), int'($urandom));
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic int sender_gap();
        if (pace == 0 || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return pick_gap(pace);
    endfunction

    // A register write occupies its own transfer; the valid is lowered at the next
    // falling edge and the task returns only at a later one, so consecutive writes are never back to back.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // The sender stops offering and waits for every predicted frame to leave, then
    // lets the pipeline settle before anything else touches the registers.
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (frames_pending != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [BANK_BITS-1:0] random_bank();
        return BANK_BITS'({$urandom, $urandom});
    endfunction

    // Receiver: free-running after reset, always accepting at pace 0 and otherwise alternating
    // accepting bursts and stalls, with a long hold-off whenever the stimulus asks for one.
    initial begin
        bit sink_open;
        sink_open = 1'b1;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (holds_asked != holds_granted) begin
                holds_granted++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            end else if (pace == 0) begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end else if (sink_open) begin
                sink_open = 1'b0;
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                sink_open = 1'b1;
                m_ready <= 1'b0;
                repeat (pick_gap(pace)) @(negedge aclk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        in_item_t directed[$];
        logic [CFG_INDEX_BITS-1:0] stray_index;
        int phase;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed items under the reset configuration: zero, blanking boundaries,
        // wrap past 999, the unsigned range from -100 to -999, multiples of a thousand,
        // the minus sign in the left and middle positions, both range ends and errors.
        directed = '{
            make_item(1'b0, 0),      make_item(1'b0, 1),      make_item(1'b0, 9),
            make_item(1'b0, 10),     make_item(1'b0, 99),     make_item(1'b0, 100),
            make_item(1'b0, 999),    make_item(1'b0, 1000),   make_item(1'b0, 2000),
            make_item(1'b0, 32767),  make_item(1'b0, -1),     make_item(1'b0, -9),
            make_item(1'b0, -10),    make_item(1'b0, -99),    make_item(1'b0, -100),
            make_item(1'b0, -999),   make_item(1'b0, -1000),  make_item(1'b0, -2000),
            make_item(1'b0, -1005),  make_item(1'b0, -1010),  make_item(1'b0, -32768),
            make_item(1'b1, 0),      make_item(1'b1, -1),     make_item(1'b1, 12345)
        };
        pace = 1;
        foreach (directed[i]) begin
            offer_item(directed[i], sender_gap());
        end

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_for_quiet();
                // Each setting is written while the block is idle: the full-scale and
                // all-clear extremes first, then the reset shapes, then random ones.
                case (phase)
                    1: begin
                        write_register(CFG_DEVICE_ADDRESS, '1);
                        write_register(CFG_MINUS_PATTERN, '1);
                        write_register(CFG_DIGITS_LOW, '1);
                        write_register(CFG_DIGITS_HIGH, '1);
                    end
                    2: begin
                        write_register(CFG_DEVICE_ADDRESS, '0);
                        write_register(CFG_MINUS_PATTERN, '0);
                        write_register(CFG_DIGITS_LOW, '0);
                        write_register(CFG_DIGITS_HIGH, '0);
                    end
                    3: begin
                        write_register(CFG_DEVICE_ADDRESS, CFG_DATA_BITS'(DEVICE_ADDRESS_RESET));
                        write_register(CFG_MINUS_PATTERN, CFG_DATA_BITS'(MINUS_PATTERN_RESET));
                        write_register(CFG_DIGITS_LOW, DIGITS_LOW_RESET);
                        write_register(CFG_DIGITS_HIGH, DIGITS_HIGH_RESET);
                    end
                    default: begin
                        write_register(CFG_DEVICE_ADDRESS, random_bank());
                        write_register(CFG_MINUS_PATTERN, random_bank());
                        write_register(CFG_DIGITS_LOW, random_bank());
                        write_register(CFG_DIGITS_HIGH, random_bank());
                    end
                endcase
                // A write to an index past the last register must change nothing.
                stray_index = CFG_INDEX_BITS'($urandom_range(int'(CFG_DIGITS_HIGH) + 1,
                                                             2 ** CFG_INDEX_BITS - 1));
                write_register(stray_index, random_bank());
            end

            pace = phase % 3;

            if (phase == 2) begin
                // The receiver holds off for a long stretch while items keep coming
                // back to back, so the pipeline fills and the input transfer stalls.
                holds_asked++;
                repeat (30) begin
                    offer_item(random_item(), 0);
                end
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 4 && n == ITEMS_PER_PHASE / 2) begin
                    wait_for_quiet();
                end
                offer_item(random_item(), sender_gap());
            end
        end

        wait_for_quiet();
        if (fail_count == 0 && frames_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
